/* hw/rtl/mvtp_pkg.sv */
// ----------------------------------------------------------------------------
// mvtp_pkg
// Shared types and constants for the two-pass mean and variance block.
// ----------------------------------------------------------------------------
package mvtp_pkg;

	// Default store depth
	localparam int MAX_SAMPLES_DEF = 1024;

	// Field widths
	localparam int SAMPLE_W   = 32;
	localparam int MEAN_W     = 32;
	localparam int VAR_W      = 63;
	localparam int STATUS_W   = 2;
	localparam int DOF_W      = 4;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_PAD_W  = OUT_DATA_W - MEAN_W - VAR_W - STATUS_W;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LOW_COUNT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MEAN_FIX,
		ST_PASS,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_EMIT
	} state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hw/rtl/mvtp_ram.sv */
// ----------------------------------------------------------------------------
// mvtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/mvtp_div.sv */
// ----------------------------------------------------------------------------
// mvtp_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvtp_div
	import mvtp_pkg::*;
#(
	parameter int NUM_W = 74,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic [NUM_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              take;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	// Control: step count, busy and one-cycle done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift numerator out, quotient bits in
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], take};
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/mean_variance_two_pass.sv */
// ----------------------------------------------------------------------------
// mean_variance_two_pass
// Two-pass mean and sample variance over a marked set of Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ channel, one transaction per cycle while
//   s_tready is high; s_tlast marks the final sample of a set. Samples past
//   MAX_SAMPLES are dropped and the set ends with the overflow status.
//   After the last sample s_tready drops while the block runs: one divide
//   for the mean, one pass over the stored samples through a single
//   subtract/square/accumulate pipeline, and one divide for the variance.
//   The divider yields one quotient bit per cycle. An overflowed set skips
//   both divides and the pass, and a set whose count does not exceed
//   dof_correction skips the pass and the variance divide. Loading runs
//   at one sample per cycle. One result transaction per set leaves on the
//   m_ channel from an output register. If the receiver stalls, the next
//   set may still be loaded; the block then waits before delivering its
//   second result until the first is taken. dof_correction is written on
//   the cfg_ channel (always ready) and must only change while the block is
//   idle. Reset clears the set counters, the register and all
//   handshakes; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
module mean_variance_two_pass
	import mvtp_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
	input  logic                  s_tlast,   // last_sample
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] mean_value, [94:32] variance_value,
	                                         // [96:95] status, [103:97] zero
	// Configuration write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DOF_W-1:0]      cfg_data   // dof_correction
);

	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES);
	localparam int SQ_W   = 2 * SAMPLE_W + $clog2(MAX_SAMPLES);
	localparam int CMP_W  = (CNT_W > DOF_W) ? CNT_W : DOF_W;

	state_t state_q, state_d;

	logic [DOF_W-1:0]         dof_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     ovf_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SQ_W-1:0]          acc_q;
	logic [CNT_W-1:0]         rd_cnt_q;

	logic [MEAN_W-1:0]        res_mean_q;
	logic [VAR_W-1:0]         res_var_q;
	logic [STATUS_W-1:0]      res_status_q;

	logic                     out_valid_q;
	logic [MEAN_W-1:0]        out_mean_q;
	logic [VAR_W-1:0]         out_var_q;
	logic [STATUS_W-1:0]      out_status_q;

	logic                     v_s2, v_s3, v_s4, v_s1;
	logic signed [SAMPLE_W:0] diff_s2;
	logic [SAMPLE_W-1:0]      mag_s3;
	logic [2*SAMPLE_W-1:0]    sq_s4;

	logic                     s_accept;
	logic                     room;
	logic                     rd_issue;
	logic                     pass_done;
	logic                     emit_go;
	logic                     low_count;
	logic [CMP_W-1:0]         count_ext;
	logic [CMP_W-1:0]         dof_ext;
	logic [CNT_W-1:0]         den_var;
	logic [SUM_W-1:0]         abs_sum;
	logic [MEAN_W:0]          mean_mag;
	logic [MEAN_W:0]          mean_neg;
	logic [SAMPLE_W:0]        neg_diff;
	logic [VAR_W-1:0]         var_sat;
	logic [SAMPLE_W-1:0]      rd_data;

	logic                     div_start;
	logic [SQ_W-1:0]          div_numer;
	logic [CNT_W-1:0]         div_denom;
	logic [SQ_W-1:0]          div_quo;
	div_stat_t                div_stat;

	// Handshake and derived control
	assign s_accept  = s_tvalid && s_tready;
	assign room      = (count_q < CNT_W'(MAX_SAMPLES));
	assign cfg_ready = 1'b1;
	assign rd_issue  = (state_q == ST_PASS) && (rd_cnt_q != count_q);
	assign pass_done = (rd_cnt_q == count_q) && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	// Count against freedom, and the variance divisor
	assign count_ext = CMP_W'(count_q);
	assign dof_ext   = CMP_W'(dof_q);
	assign low_count = (count_ext <= dof_ext);
	assign den_var   = CNT_W'(count_ext - dof_ext);

	// Sum magnitude and signed mean from the quotient
	assign abs_sum  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mean_mag = div_quo[MEAN_W:0];
	assign mean_neg = -mean_mag;

	// Saturate the variance quotient to 63 bits
	assign var_sat = (|div_quo[SQ_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_quo[VAR_W-1:0];

	// Divider operand select
	assign div_numer = (state_q == ST_VAR_GO) ? acc_q : SQ_W'(abs_sum);
	assign div_denom = (state_q == ST_VAR_GO) ? den_var : count_q;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ovf_q ? ST_EMIT : ST_MEAN_GO;
			end
			ST_MEAN_GO: begin
				div_start = !div_stat.busy;
				if (!div_stat.busy) begin
					state_d = ST_MEAN_WAIT;
				end
			end
			ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_MEAN_FIX;
				end
			end
			ST_MEAN_FIX: begin
				state_d = low_count ? ST_EMIT : ST_PASS;
			end
			ST_PASS: begin
				if (pass_done) begin
					state_d = ST_VAR_GO;
				end
			end
			ST_VAR_GO: begin
				div_start = !div_stat.busy;
				if (!div_stat.busy) begin
					state_d = ST_VAR_WAIT;
				end
			end
			ST_VAR_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dof_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dof_q <= cfg_data;
		end
	end

	// Set bookkeeping: count, running sum, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (emit_go) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (s_accept) begin
			if (room) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'($signed(s_tdata));
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Sample store
	mvtp_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (s_accept && room),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (rd_issue),
		.raddr (rd_cnt_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// Shared divider for the mean and the variance
	mvtp_div #(
		.NUM_W (SQ_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.denom    (div_denom),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Mean, pass read pointer, and results per state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (state_q == ST_MEAN_FIX) begin
			rd_cnt_q <= '0;
		end else if (rd_issue) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				res_mean_q   <= '0;
				res_var_q    <= '0;
				res_status_q <= STATUS_OVERFLOW;
			end
			ST_MEAN_FIX: begin
				mean_q       <= $signed(sum_q[SUM_W-1] ? mean_neg[MEAN_W-1:0]
				                                       : mean_mag[MEAN_W-1:0]);
				res_mean_q   <= sum_q[SUM_W-1] ? mean_neg[MEAN_W-1:0] : mean_mag[MEAN_W-1:0];
				res_var_q    <= '0;
				res_status_q <= low_count ? STATUS_LOW_COUNT : STATUS_OK;
			end
			ST_VAR_WAIT: begin
				if (div_stat.done) begin
					res_var_q <= var_sat;
				end
			end
			default: begin
			end
		endcase
	end

	// Pass pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Pass pipeline: difference, magnitude, square
	assign neg_diff = -diff_s2;

	always_ff @(posedge clk) begin
		diff_s2 <= $signed({rd_data[SAMPLE_W-1], rd_data}) - $signed({mean_q[MEAN_W-1], mean_q});
		mag_s3  <= diff_s2[SAMPLE_W] ? neg_diff[SAMPLE_W-1:0] : diff_s2[SAMPLE_W-1:0];
		sq_s4   <= mag_s3 * mag_s3;
	end

	// Accumulate squared differences
	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN_FIX) begin
			acc_q <= '0;
		end else if (v_s4) begin
			acc_q <= acc_q + SQ_W'(sq_s4);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_mean_q   <= res_mean_q;
			out_var_q    <= res_var_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_status_q, out_var_q, out_mean_q};

endmodule

/* hw/rtl/mvtp_chk.sv */
// ----------------------------------------------------------------------------
// mvtp_chk
// Port-level checks for the two-pass mean and variance block.
// ----------------------------------------------------------------------------
module mvtp_chk
	import mvtp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0] st;

	assign st = m_tdata[MEAN_W+VAR_W+STATUS_W-1:MEAN_W+VAR_W];

	// Hold a stalled result transaction
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// Stop taking samples once a set is closed
	a_close_set: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("sample taken right after the last one");

	// Overflowed set carries zero mean and variance
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == STATUS_OVERFLOW) |-> (m_tdata[MEAN_W+VAR_W-1:0] == '0))
		else $error("overflow result has nonzero fields");

	// Low count carries zero variance, and no undefined status appears
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == STATUS_OK) || (st == STATUS_OVERFLOW) ||
		((st == STATUS_LOW_COUNT) && (m_tdata[MEAN_W+VAR_W-1:MEAN_W] == '0)))
		else $error("bad status or nonzero variance on low count");

endmodule

bind mean_variance_two_pass mvtp_chk u_mvtp_chk (.*);
